// ===== design/signed_integer_to_radix_text_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the radix text converter
// Shared checks on clock and reset, compiled out under NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef SIGNED_INTEGER_TO_RADIX_TEXT_TOP_DEFINES_SVH
`define SIGNED_INTEGER_TO_RADIX_TEXT_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Consequent must hold in the same cycle as the antecedent
`define SITRT_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Consequent must hold in the cycle after the antecedent
`define SITRT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SITRT_ASSERT_SAME(label, ante, cons, msg)
`define SITRT_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== design/sitrt_pkg.sv =====
// ----------------------------------------------------------------------------
// sitrt_pkg
// Types and constants shared by the radix text controller and datapath.
// ----------------------------------------------------------------------------
package sitrt_pkg;

   localparam int VALUE_W  = 64;
   localparam int CHAR_W   = 7;
   localparam int RADIX_W  = 5;
   localparam int DIGIT_W  = 4;
   localparam int ADDR_W   = 6;
   localparam int DEPTH    = 64;

   localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
   localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

   // Byte lanes of the dividend, worked top lane first
   localparam logic [2:0] STEP_TOP = 3'd7;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
   localparam logic [CHAR_W-1:0] CHAR_A     = 7'h61;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;
   localparam logic [DIGIT_W-1:0] DIGIT_TEN = 4'd10;

   // Commands from controller to datapath
   typedef struct packed {
      logic load;
      logic div;
      logic emit_sign;
      logic emit_digit;
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic last_step;
      logic quo_zero;
      logic neg;
      logic ptr_zero;
      logic out_free;
   } sts_type;

   // Map one digit value to its lower-case ASCII character
   function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] c;
      if (d < DIGIT_TEN) begin
         c = CHAR_ZERO + {3'b000, d};
      end else begin
         c = CHAR_A + {3'b000, d - DIGIT_TEN};
      end
      return c;
   endfunction

endpackage

// ===== design/signed_integer_to_radix_text_top.sv =====
// Each digit takes a division of the 64-bit dividend by the base, worked one
// byte lane per cycle, top lane first; a sign state then fetches the top digit
// and emits any minus sign, and the digits follow one per cycle while the sink
// has room for them, for values of either sign alike.
// One item at a time; the worst case is base 2 with 63 digits.
// Reset is synchronous, active high, and sets the radix to ten.
// ----------------------------------------------------------------------------
// signed_integer_to_radix_text_top
// Converts a signed 64-bit value into ASCII text in a base from 2 to 16.
// ----------------------------------------------------------------------------
module signed_integer_to_radix_text_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wen,
   input  logic [sitrt_pkg::RADIX_W-1:0] csr_wdata,    // radix
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [63:0]                   req_tdata,    // [63:0] value
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [7:0]                    rsp_tdata,    // [6:0] text_char, [7] zero
   output logic                          rsp_tlast
);
   import sitrt_pkg::*;

   cmd_type            cmd;
   sts_type            sts;
   logic [CHAR_W-1:0]  rsp_char;

   sitrt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   sitrt_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_value  (req_tdata),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_char   (rsp_char),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {1'b0, rsp_char};

endmodule

// ===== design/sitrt_ctrl.sv =====
// ----------------------------------------------------------------------------
// sitrt_ctrl
// Sequencer: accept an item, run the digit divisions, then emit the text.
// ----------------------------------------------------------------------------
`include "signed_integer_to_radix_text_top_defines.svh"

module sitrt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  sitrt_pkg::sts_type sts,
   output sitrt_pkg::cmd_type cmd
);
   import sitrt_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_DIV,
      S_SIGN,
      S_DIGIT
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid && ready_ff) begin
               cmd.load = 1'b1;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div = 1'b1;
            if (sts.last_step && sts.quo_zero) begin
               state_in = S_SIGN;
            end
         end
         S_SIGN: begin
            if (!sts.neg) begin
               state_in = S_DIGIT;
            end else if (sts.out_free) begin
               cmd.emit_sign = 1'b1;
               state_in      = S_DIGIT;
            end
         end
         S_DIGIT: begin
            if (sts.out_free) begin
               cmd.emit_digit = 1'b1;
               if (sts.ptr_zero) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold state and the registered ready
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= (state_in == S_IDLE);
      end
   end

   assign req_tready = ready_ff;

   `SITRT_ASSERT_SAME(a_cmd_onehot, 1'b1, $onehot0({cmd.load, cmd.div, cmd.emit_sign, cmd.emit_digit}), "more than one datapath command")
   `SITRT_ASSERT_NEXT(a_load_starts_div, cmd.load, (state_ff == S_DIV) && !req_tready, "accepted item did not start division")

endmodule

// ===== design/sitrt_datapath.sv =====
// ----------------------------------------------------------------------------
// sitrt_datapath
// Radix register, byte-serial divider, digit store and output register.
// ----------------------------------------------------------------------------
`include "signed_integer_to_radix_text_top_defines.svh"

module sitrt_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wen,
   input  logic [sitrt_pkg::RADIX_W-1:0]   csr_wdata,
   input  logic [sitrt_pkg::VALUE_W-1:0]   req_value,
   input  sitrt_pkg::cmd_type              cmd,
   output sitrt_pkg::sts_type              sts,
   input  logic                            rsp_tready,
   output logic                            rsp_tvalid,
   output logic [sitrt_pkg::CHAR_W-1:0]    rsp_char,
   output logic                            rsp_last
);
   import sitrt_pkg::*;

   logic [RADIX_W-1:0] radix_ff;
   logic [RADIX_W-1:0] eff_radix;
   logic [RADIX_W-1:0] base_ff;
   logic               neg_ff;
   logic [VALUE_W-1:0] quo_ff, quo_in, quo_step;
   logic [DIGIT_W-1:0] rem_ff, rem_in, rem_step;
   logic [2:0]         step_ff, step_in;
   logic [ADDR_W-1:0]  nd_ff, nd_in;
   logic [ADDR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [DIGIT_W-1:0] rdata_ff;
   logic               mem_we;
   logic [DIGIT_W-1:0] digit_mem [DEPTH];
   logic [VALUE_W-1:0] sat_value;
   logic [VALUE_W-1:0] mag;
   logic [7:0]         div_byte, q_byte;
   logic [RADIX_W-1:0] part;
   logic               out_valid_ff, out_valid_in;
   logic [CHAR_W-1:0]  out_char_ff, out_char_in;
   logic               out_last_ff, out_last_in;
   logic               digit_done;

   // Clamp the configured radix to the supported range
   always_comb begin
      if (radix_ff < RADIX_MIN) begin
         eff_radix = RADIX_MIN;
      end else if (radix_ff > RADIX_MAX) begin
         eff_radix = RADIX_MAX;
      end else begin
         eff_radix = radix_ff;
      end
   end

   // Saturate the most negative value, then take the magnitude
   always_comb begin
      if (req_value == {1'b1, {(VALUE_W-1){1'b0}}}) begin
         sat_value = {1'b1, {(VALUE_W-2){1'b0}}, 1'b1};
      end else begin
         sat_value = req_value;
      end
      mag = req_value[VALUE_W-1] ? (~sat_value + 1'b1) : sat_value;
   end

   // One byte of long division by the base: eight restoring steps
   always_comb begin
      div_byte = quo_ff[{step_ff, 3'b000} +: 8];
      part     = {1'b0, rem_ff};
      q_byte   = '0;
      for (int j = 7; j >= 0; j--) begin
         part = {part[RADIX_W-2:0], div_byte[j]};
         if (part >= base_ff) begin
            part      = part - base_ff;
            q_byte[j] = 1'b1;
         end
      end
      quo_step = quo_ff;
      quo_step[{step_ff, 3'b000} +: 8] = q_byte;
      rem_step = part[DIGIT_W-1:0];
   end

   assign digit_done = cmd.div && (step_ff == '0);
   assign mem_we     = digit_done;

   // Advance the divider state
   always_comb begin
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      step_in   = step_ff;
      nd_in     = nd_ff;
      rd_ptr_in = rd_ptr_ff;
      if (cmd.load) begin
         quo_in  = mag;
         rem_in  = '0;
         step_in = STEP_TOP;
         nd_in   = '0;
      end else if (cmd.div) begin
         quo_in  = quo_step;
         step_in = step_ff - 1'b1;
         if (step_ff == '0) begin
            rem_in    = '0;
            nd_in     = nd_ff + 1'b1;
            rd_ptr_in = nd_ff;
         end else begin
            rem_in = rem_step;
         end
      end else if (cmd.emit_digit) begin
         rd_ptr_in = rd_ptr_ff - 1'b1;
      end
   end

   // Load the output register or drop a taken item
   always_comb begin
      out_valid_in = out_valid_ff;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      if (cmd.emit_sign) begin
         out_valid_in = 1'b1;
         out_char_in  = CHAR_MINUS;
         out_last_in  = 1'b0;
      end else if (cmd.emit_digit) begin
         out_valid_in = 1'b1;
         out_char_in  = digit_char(rdata_ff);
         out_last_in  = (rd_ptr_ff == '0);
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff     <= RADIX_RESET;
         out_valid_ff <= 1'b0;
         step_ff      <= '0;
         nd_ff        <= '0;
         rd_ptr_ff    <= '0;
      end else begin
         if (csr_wen) begin
            radix_ff <= csr_wdata;
         end
         out_valid_ff <= out_valid_in;
         step_ff      <= step_in;
         nd_ff        <= nd_in;
         rd_ptr_ff    <= rd_ptr_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         base_ff <= eff_radix;
         neg_ff  <= req_value[VALUE_W-1];
      end
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   // Digit store, least significant digit written first
   always_ff @(posedge clock) begin
      if (mem_we) begin
         digit_mem[nd_ff] <= rem_step;
      end
      rdata_ff <= digit_mem[rd_ptr_in];
   end

   assign sts.last_step = (step_ff == '0);
   assign sts.quo_zero  = (quo_step == '0);
   assign sts.neg       = neg_ff;
   assign sts.ptr_zero  = (rd_ptr_ff == '0);
   assign sts.out_free  = !out_valid_ff || rsp_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_char   = out_char_ff;
   assign rsp_last   = out_last_ff;

   `SITRT_ASSERT_SAME(a_emit_needs_room, cmd.emit_sign || cmd.emit_digit, !out_valid_ff || rsp_tready, "character overwrites a pending item")
   `SITRT_ASSERT_SAME(a_rem_below_base, cmd.div, rem_ff < base_ff, "remainder not below base")
   `SITRT_ASSERT_SAME(a_base_range, cmd.div, (base_ff >= RADIX_MIN) && (base_ff <= RADIX_MAX), "base out of range")

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// Testbench for signed_integer_to_radix_text_top
// Sends signed 64-bit values and compares every emitted character and its
// last flag with a behavioural prediction of the text. The prediction covers
// saturated radix values, the most negative input and zero. Both stream sides
// stall at random, and the radix is rewritten between phases while idle.
// ----------------------------------------------------------------------------
module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   import sitrt_pkg::*;

   localparam logic [63:0] VALUE_MAX   = 64'h7fff_ffff_ffff_ffff;
   localparam logic [63:0] VALUE_MIN   = 64'h8000_0000_0000_0000;
   localparam int          PHASES      = 12;
   localparam int          PHASE_ITEMS = 38;
   localparam int          END_CYCLES  = 600;

   // One expected character of the text
   typedef struct {
      logic [CHAR_W-1:0] text_char;
      logic              last;
   } text_char_type;

   // Predicts the text of each value and checks emitted characters in order
   class text_scoreboard;
      logic [RADIX_W-1:0] radix;
      text_char_type      text_q[$];
      int                 errors;

      function new();
         radix  = RADIX_RESET;
         errors = 0;
      endfunction

      function void set_radix(logic [RADIX_W-1:0] r);
         radix = r;
      endfunction

      function int pending();
         return text_q.size();
      endfunction

      task report(string msg);
         $display("ERROR @%0t: %s", $realtime, msg);
         errors++;
      endtask

      // Work out the characters for one accepted value
      function void note_value(logic [63:0] value);
         logic [63:0]       mag;
         logic [63:0]       base;
         logic [DIGIT_W-1:0] digit_q[$];
         text_char_type     c;
         logic [DIGIT_W-1:0] d;

         // saturate the base to the legal range
         if (radix < RADIX_MIN) base = 64'(RADIX_MIN);
         else if (radix > RADIX_MAX) base = 64'(RADIX_MAX);
         else base = 64'(radix);

         if (value[63]) begin
            mag = (value == VALUE_MIN) ? VALUE_MAX : (~value + 64'd1);
            c.text_char = CHAR_MINUS;
            c.last      = 1'b0;
            text_q.push_back(c);
         end else begin
            mag = value;
         end

         // collect digits, most significant first
         if (mag == 64'd0) digit_q.push_back('0);
         while (mag != 64'd0) begin
            digit_q.push_front(DIGIT_W'(mag % base));
            mag = mag / base;
         end

         foreach (digit_q[i]) begin
            d = digit_q[i];
            if (d < DIGIT_TEN) c.text_char = CHAR_ZERO + CHAR_W'(d);
            else c.text_char = CHAR_A + CHAR_W'(d - DIGIT_TEN);
            c.last = (i == digit_q.size() - 1);
            text_q.push_back(c);
         end
      endfunction

      // Compare one emitted character with the oldest expectation
      task check_char(logic [7:0] data, logic last);
         text_char_type e;
         if (text_q.size() == 0) begin
            report($sformatf("unexpected character 0x%02h last %0b", data, last));
         end else begin
            e = text_q.pop_front();
            if (data[CHAR_W-1:0] !== e.text_char)
               report($sformatf("text_char 0x%02h, predicted 0x%02h",
                                data[CHAR_W-1:0], e.text_char));
            if (data[7] !== 1'b0)
               report("padding bit of rsp_tdata is not zero");
            if (last !== e.last)
               report($sformatf("last %0b, predicted %0b", last, e.last));
         end
      endtask
   endclass

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               csr_wen    = 1'b0;
   logic [RADIX_W-1:0] csr_wdata  = '0;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [63:0]        req_tdata  = '0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [7:0]         rsp_tdata;
   logic               rsp_tlast;

   int             tx_idle_pct = 0;
   int             rx_idle_pct = 0;
   text_scoreboard book = new();

   signed_integer_to_radix_text_top uut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Stall the result side at random
   always @(posedge clock) begin
      rsp_tready <= reset ? 1'b0 : ($urandom_range(99) >= rx_idle_pct);
   end

   // Check every accepted character
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) book.check_char(rsp_tdata, rsp_tlast);
   end

   // Set the idling pattern: 0 slow receiver side, 1 slow sender side, 2 none
   task set_idling(int mode);
      case (mode)
         0: begin
            tx_idle_pct = 28;
            rx_idle_pct = 83;
         end
         1: begin
            tx_idle_pct = 83;
            rx_idle_pct = 28;
         end
         default: begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
      endcase
   endtask

   // Offer one value, with a random gap ahead, and hold it until accepted
   task send_value(logic [63:0] value);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      book.note_value(value);
   endtask

   // Drop valid and wait until all predicted text has arrived
   task drain();
      req_tvalid <= 1'b0;
      while (book.pending() != 0) @(posedge clock);
   endtask

   // Write the radix register while the block is idle
   task write_radix(logic [RADIX_W-1:0] r);
      drain();
      csr_wen   <= 1'b1;
      csr_wdata <= r;
      @(posedge clock);
      csr_wen   <= 1'b0;
      book.set_radix(r);
   endtask

   // Stop a hung run
   initial begin
      #30_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      logic [RADIX_W-1:0] phase_radix[PHASES];
      logic [63:0]        value;
      int unsigned        width;

      phase_radix = '{5'd31, 5'd0, 5'd1, 5'd2, 5'd16, 5'd17,
                      5'd7, 5'd3, 5'd13, 5'd10, 5'd8, 5'd5};

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      set_idling(0);

      // Directed values at the reset radix of ten
      send_value(64'd0);
      send_value(64'd1);
      send_value(-64'sd1);
      send_value(64'd9);
      send_value(64'd10);
      send_value(-64'sd10);
      send_value(VALUE_MAX);
      send_value(VALUE_MIN);
      send_value(VALUE_MIN + 64'd1);
      send_value(64'h0123_4567_89ab_cdef);

      // Longest texts in base two
      write_radix(5'd2);
      send_value(VALUE_MIN);
      send_value(VALUE_MAX);
      send_value(-64'sd1);
      send_value(64'd0);
      send_value(64'd1);

      // All hex digits in base sixteen
      write_radix(5'd16);
      send_value(64'hfedc_ba98_7654_3210);
      send_value(64'h0123_4567_89ab_cdef);
      send_value(64'd15);
      send_value(-64'sd15);
      send_value(VALUE_MIN + 64'd1);

      // Random values of random magnitude, one radix per phase
      for (int ph = 0; ph < PHASES; ph++) begin
         write_radix(phase_radix[ph]);
         set_idling(ph / 4);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            case ($urandom_range(15))
               0: value = 64'd0;
               1: value = VALUE_MAX;
               2: value = VALUE_MIN;
               default: begin
                  width = $urandom_range(64, 1);
                  value = {$urandom, $urandom} >> (64 - width);
                  if ($urandom_range(1) == 1) value = ~value + 64'd1;
               end
            endcase
            send_value(value);
         end
      end

      drain();
      repeat (END_CYCLES) @(posedge clock);

      if (book.errors == 0 && book.pending() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== signed_integer_to_radix_text_top.f =====
+incdir+design
design/sitrt_pkg.sv
design/sitrt_ctrl.sv
design/sitrt_datapath.sv
design/signed_integer_to_radix_text_top.sv
sim/testbench.sv
